// ===== hw/rtl/mbe_pkg.sv =====
// Package for the Mandelbrot escape-time unit: configuration struct, register
// indexes, sequencer states, fixed-point constants and the Q4.28 saturation helper.
// No dependencies.
`timescale 1ns / 1ps

package mbe_pkg;

  // Fixed-point format: signed Q4.28 in 32 bits, products Q8.56 in 64 bits.
  localparam int FRAC_BITS = 28;

  // Escape threshold 4.0 in Q8.56.
  localparam logic [63:0] ESCAPE_LIMIT = 64'h0400_0000_0000_0000;

  // Register reset values.
  localparam logic signed [31:0] X_ORIGIN_RST = -32'sd671088640;
  localparam logic signed [31:0] Y_ORIGIN_RST = -32'sd402653184;
  localparam logic [30:0]        X_STEP_RST   = 31'd1468006;
  localparam logic [30:0]        Y_STEP_RST   = 31'd1572864;
  localparam logic [7:0]         MAX_ITER_RST = 8'd255;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_X_ORIGIN = 3'd0,
    REG_Y_ORIGIN = 3'd1,
    REG_X_STEP   = 3'd2,
    REG_Y_STEP   = 3'd3,
    REG_MAX_ITER = 3'd4
  } cfg_reg_t;

  // Current configuration as seen by the core.
  typedef struct packed {
    logic signed [31:0] x_origin;
    logic signed [31:0] y_origin;
    logic [30:0]        x_step;
    logic [30:0]        y_step;
    logic [7:0]         max_iterations;
  } cfg_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CX,
    ST_CY,
    ST_CYSAT,
    ST_XX,
    ST_YY,
    ST_XY,
    ST_UPD,
    ST_DONE
  } state_t;

  // Saturate a 64-bit signed value to the Q4.28 range.
  function automatic logic signed [31:0] sat_q(input logic signed [63:0] v);
    logic signed [31:0] r;
    if ((&v[63:31]) || !(|v[63:31])) begin
      r = v[31:0];
    end else if (v[63]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/mbe_mul.sv =====
// Shared signed 32x32 multiplier with a registered 64-bit product.
// Depends on nothing; used by mbe_core for all products.
`timescale 1ns / 1ps

module mbe_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] p
);

  // One product per cycle, available the cycle after the operands.
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== hw/rtl/mbe_core.sv =====
// Sequencer and datapath of the escape-time unit: forms c, iterates z = z^2 + c
// on the shared multiplier and counts iterations. Depends on mbe_pkg.
`timescale 1ns / 1ps

module mbe_core (
  input  logic                clk,
  input  logic                rst,
  input  mbe_pkg::cfg_t       cfg,
  // Pixel input
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [9:0]          in_x,
  input  logic [8:0]          in_y,
  // Result output
  output logic                res_valid,
  input  logic                res_ready,
  output logic [7:0]          res_count,
  output logic [9:0]          res_x,
  output logic [8:0]          res_y,
  // Shared multiplier
  output logic signed [31:0]  mul_a,
  output logic signed [31:0]  mul_b,
  input  logic signed [63:0]  mul_p
);

  mbe_pkg::state_t state, state_next;

  logic [9:0]         px;
  logic [8:0]         py;
  logic signed [31:0] cx, cy, zx, zy;
  logic signed [63:0] xx, yy;
  logic [7:0]         count;

  logic [63:0]        mag;
  logic               stop;
  logic signed [63:0] diff, nx_wide, ny_wide, cx_wide, cy_wide;

  // Escape and limit test on the registered squares.
  assign mag  = $unsigned(xx) + $unsigned(yy);
  assign stop = (mag > mbe_pkg::ESCAPE_LIMIT) || (count >= cfg.max_iterations);

  // Next iterate; the product register holds zx*zy during the update state.
  // Every operand stays signed so that the shifts round toward minus infinity.
  assign diff    = xx - yy;
  assign nx_wide = (diff >>> mbe_pkg::FRAC_BITS) + 64'(cx);
  assign ny_wide = (mul_p >>> (mbe_pkg::FRAC_BITS - 1)) + 64'(cy);

  // Point coordinates from origin plus product.
  assign cx_wide = {{32{cfg.x_origin[31]}}, cfg.x_origin} + mul_p;
  assign cy_wide = {{32{cfg.y_origin[31]}}, cfg.y_origin} + mul_p;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, handshakes and multiplier operand selection.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    mul_a      = zx;
    mul_b      = zx;
    unique case (state)
      mbe_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = mbe_pkg::ST_CX;
      end
      mbe_pkg::ST_CX: begin
        mul_a      = signed'({1'b0, cfg.x_step});
        mul_b      = signed'({22'd0, px});
        state_next = mbe_pkg::ST_CY;
      end
      mbe_pkg::ST_CY: begin
        mul_a      = signed'({1'b0, cfg.y_step});
        mul_b      = signed'({23'd0, py});
        state_next = mbe_pkg::ST_CYSAT;
      end
      mbe_pkg::ST_CYSAT: begin
        state_next = mbe_pkg::ST_XX;
      end
      mbe_pkg::ST_XX: begin
        state_next = mbe_pkg::ST_YY;
      end
      mbe_pkg::ST_YY: begin
        mul_a      = zy;
        mul_b      = zy;
        state_next = mbe_pkg::ST_XY;
      end
      mbe_pkg::ST_XY: begin
        mul_b      = zy;
        state_next = mbe_pkg::ST_UPD;
      end
      mbe_pkg::ST_UPD: begin
        state_next = stop ? mbe_pkg::ST_DONE : mbe_pkg::ST_XX;
      end
      mbe_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) state_next = mbe_pkg::ST_IDLE;
      end
      default: state_next = mbe_pkg::ST_IDLE;
    endcase
  end

  // Datapath registers, loaded by state.
  always_ff @(posedge clk) begin
    unique case (state)
      mbe_pkg::ST_IDLE: begin
        if (in_valid) begin
          px <= in_x;
          py <= in_y;
        end
      end
      mbe_pkg::ST_CY: begin
        cx <= mbe_pkg::sat_q(cx_wide);
      end
      mbe_pkg::ST_CYSAT: begin
        cy    <= mbe_pkg::sat_q(cy_wide);
        zx    <= '0;
        zy    <= '0;
        count <= '0;
      end
      mbe_pkg::ST_YY: begin
        xx <= mul_p;
      end
      mbe_pkg::ST_XY: begin
        yy <= mul_p;
      end
      mbe_pkg::ST_UPD: begin
        if (!stop) begin
          zx    <= mbe_pkg::sat_q(nx_wide);
          zy    <= mbe_pkg::sat_q(ny_wide);
          count <= count + 8'd1;
        end
      end
      default: ;
    endcase
  end

  assign res_count = count;
  assign res_x     = px;
  assign res_y     = py;

  // An accepted pixel always starts with the real-part product.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (state == mbe_pkg::ST_IDLE && in_valid) |=> state == mbe_pkg::ST_CX)
    else $error("pixel accepted but sequencer did not start");

  // Every pixel starts its iterations from z = 0 with a cleared count.
  a_iter_init: assert property (@(posedge clk) disable iff (rst)
    state == mbe_pkg::ST_CYSAT |=> (count == 8'd0 && zx == 32'sd0 && zy == 32'sd0))
    else $error("iterate not cleared before first step");

  // A step that does not stop advances the count by exactly one.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state == mbe_pkg::ST_UPD && !stop) |=> count == $past(count) + 8'd1)
    else $error("iteration count did not advance");

endmodule

// ===== hw/rtl/mandelbrot_escape_time.sv =====
// Top level of the Mandelbrot escape-time unit: configuration registers, output
// register and the stream ports. Depends on mbe_pkg, mbe_mul and mbe_core.
//
//  Channel   Dir   Handshake                    Payload
//  s_axis    in    s_axis_tvalid/s_axis_tready  pixel_x, pixel_y
//  m_axis    out   m_axis_tvalid/m_axis_tready  iter_count, out_x, out_y
//  cfg       in    cfg_valid/cfg_ready          cfg_index, cfg_data
//
// A pixel passes through ST_CX, ST_CY and ST_CYSAT, then through one pass of the loop
// per iteration and a last pass, before its result is offered on m_axis; each pass
// uses the one shared multiplier for three products and then an update state, and the
// last pass only tests for the stop.
// One pixel is in work at a time; the next is accepted once the result is in
// the output register, which holds it while m_axis_tready is low.
// rst is synchronous and restores the register reset values; cfg_ready is
// always high.
`timescale 1ns / 1ps

module mandelbrot_escape_time (
  input  logic        clk,
  input  logic        rst,
  // Pixel input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [9:0] pixel_x, [18:10] pixel_y, rest zero
  // Result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] iter_count, [17:8] out_x, [26:18] out_y
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  mbe_pkg::cfg_t      cfg;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic               res_valid, res_ready;
  logic [7:0]         res_count;
  logic [9:0]         res_x;
  logic [8:0]         res_y;

  logic [7:0]         iter_count;
  logic [9:0]         out_x;
  logic [8:0]         out_y;

  assign cfg_ready = 1'b1;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_origin       <= mbe_pkg::X_ORIGIN_RST;
      cfg.y_origin       <= mbe_pkg::Y_ORIGIN_RST;
      cfg.x_step         <= mbe_pkg::X_STEP_RST;
      cfg.y_step         <= mbe_pkg::Y_STEP_RST;
      cfg.max_iterations <= mbe_pkg::MAX_ITER_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mbe_pkg::REG_X_ORIGIN: cfg.x_origin       <= cfg_data;
        mbe_pkg::REG_Y_ORIGIN: cfg.y_origin       <= cfg_data;
        mbe_pkg::REG_X_STEP:   cfg.x_step         <= cfg_data[30:0];
        mbe_pkg::REG_Y_STEP:   cfg.y_step         <= cfg_data[30:0];
        mbe_pkg::REG_MAX_ITER: cfg.max_iterations <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  mbe_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  mbe_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_x      (s_axis_tdata[9:0]),
    .in_y      (s_axis_tdata[18:10]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_count (res_count),
    .res_x     (res_x),
    .res_y     (res_y),
    .mul_a     (mul_a),
    .mul_b     (mul_b),
    .mul_p     (mul_p)
  );

  // Output register: takes a result whenever it is empty or being drained.
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      iter_count <= res_count;
      out_x      <= res_x;
      out_y      <= res_y;
    end
  end

  assign m_axis_tdata = {5'd0, out_y, out_x, iter_count};

endmodule
